// ===== src/tlbr_pkg.sv =====
// Shared types, constants and functions of the TLB replacement lookup.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tlbr_pkg;

   localparam int ENTRIES_DEFAULT   = 16;
   localparam int PAGE_BITS_DEFAULT = 20;

   localparam int POLICY_BITS    = 2;
   localparam int LIMIT_BITS     = 5;
   localparam int LFSR_BITS      = 16;
   localparam int COUNT_BITS     = 32;
   localparam int EVICT_BITS     = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // policy codes; the spare code behaves as FIFO
   localparam logic [POLICY_BITS-1:0] POLICY_FIFO   = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_LRU    = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_RANDOM = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED   = 2'd2;

   localparam logic [POLICY_BITS-1:0] POLICY_RESET = POLICY_FIFO;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 5'd16;
   localparam logic [LFSR_BITS-1:0]   SEED_RESET   = 16'd44257;
   localparam logic [LFSR_BITS-1:0]   LFSR_MASK    = 16'hB400;

   typedef struct packed {
      logic [POLICY_BITS-1:0] policy;
      logic [LIMIT_BITS-1:0]  limit;
   } tlbr_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } tlbr_div_status_type;

   // Galois LFSR, shifting right
   function automatic logic [LFSR_BITS-1:0] tlbr_lfsr_next(input logic [LFSR_BITS-1:0] v);
      logic [LFSR_BITS-1:0] s;
      s = v >> 1;
      if (v[0]) begin
         s = s ^ LFSR_MASK;
      end
      return s;
   endfunction

   // a zero seed would lock the LFSR up
   function automatic logic [LFSR_BITS-1:0] tlbr_seed(input logic [LFSR_BITS-1:0] s);
      return (s == '0) ? LFSR_BITS'(1) : s;
   endfunction

endpackage

`default_nettype wire

// ===== src/tlbr_if.sv =====
// Valid/ready channel interfaces for lookup requests and responses.
// Depends on tlbr_pkg for the fixed field widths.
`default_nettype none

interface tlbr_req_if
   import tlbr_pkg::*;
#(
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface tlbr_rsp_if
   import tlbr_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic                  evicted_valid;
   logic [EVICT_BITS-1:0] evicted_page;
   logic [COUNT_BITS-1:0] hit_total;
   logic [COUNT_BITS-1:0] miss_total;

   modport source (output valid, output hit, output evicted_valid, output evicted_page,
                   output hit_total, output miss_total, input ready);
   modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                   input hit_total, input miss_total, output ready);
endinterface

`default_nettype wire

// ===== src/tlbr_modulo.sv =====
// Restoring remainder unit: LFSR value mod occupancy, one bit per cycle.
// Depends on tlbr_pkg.
`default_nettype none

module tlbr_modulo
   import tlbr_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [LFSR_BITS-1:0]             dividend,
   input  wire  [$clog2(ENTRIES+1)-1:0]     divisor,
   output tlbr_div_status_type              status,
   output logic [$clog2(ENTRIES+1)-1:0]     remainder
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CNT_W = $clog2(LFSR_BITS);

   logic [LFSR_BITS-1:0] dvd_ff;
   logic [OCC_W-1:0]     dvs_ff;
   logic [OCC_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [OCC_W:0] trial;
   logic [OCC_W:0] step_rem;

   always_comb begin
      trial    = {rem_ff, dvd_ff[LFSR_BITS-1]};
      step_rem = (trial >= {1'b0, dvs_ff}) ? trial - {1'b0, dvs_ff} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff   <= dividend;
            dvs_ff   <= divisor;
            rem_ff   <= '0;
            count_ff <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= step_rem[OCC_W-1:0];
            dvd_ff   <= dvd_ff << 1;
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(LFSR_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

// ===== src/tlbr_engine.sv =====
// Lookup sequencer: entry table memory, serial compare scan, shift-down
// compaction, counters and the response register. Uses tlbr_modulo.
// Depends on tlbr_pkg and the channel interfaces in tlbr_if.
`default_nettype none

module tlbr_engine
   import tlbr_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  tlbr_cfg_type         cfg,
   input  wire  [LFSR_BITS-1:0]       lfsr_adv,
   output logic                       lfsr_step,
   tlbr_req_if.sink                   req,
   tlbr_rsp_if.source                 rsp
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW    = (OCC_W > LIMIT_BITS) ? OCC_W : LIMIT_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MODWAIT, ST_VREAD, ST_VCAP, ST_SHIFT, ST_APPEND, ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [OCC_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [OCC_W-1:0]      src_ff, src_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0] miss_cnt_ff, miss_cnt_in;
   logic                  hit_ff, hit_in;
   logic                  evict_ff, evict_in;
   logic                  removing_ff, removing_in;
   logic [PAGE_BITS-1:0]  evpage_ff, evpage_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_evv_ff, rsp_evv_in;
   logic [EVICT_BITS-1:0] rsp_evp_ff, rsp_evp_in;
   logic [COUNT_BITS-1:0] rsp_hits_ff, rsp_hits_in;
   logic [COUNT_BITS-1:0] rsp_miss_ff, rsp_miss_in;

   // table memory, one write and one registered read per cycle
   logic [PAGE_BITS-1:0]  mem [ENTRIES];
   logic [PAGE_BITS-1:0]  mem_rd_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [PAGE_BITS-1:0]  mem_wd;

   logic                  mod_start;
   tlbr_div_status_type   mod_status;
   logic [OCC_W-1:0]      mod_rem;

   logic [LW-1:0]         lim_raw, lim_eff;
   logic                  table_full;
   logic                  pol_lru, pol_rand;
   logic [PAGE_BITS+EVICT_BITS-1:0] ev_wide;

   tlbr_modulo #(.ENTRIES(ENTRIES)) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (lfsr_adv),
      .divisor   (occ_ff),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   always_comb begin
      lim_raw = LW'(cfg.limit);
      if (lim_raw == '0) begin
         lim_eff = LW'(1);
      end else if (lim_raw > LW'(ENTRIES)) begin
         lim_eff = LW'(ENTRIES);
      end else begin
         lim_eff = lim_raw;
      end
      table_full = LW'(occ_ff) >= lim_eff;
      pol_lru    = cfg.policy == POLICY_LRU;
      pol_rand   = cfg.policy == POLICY_RANDOM;
      ev_wide    = {{EVICT_BITS{1'b0}}, evpage_ff};
   end

   always_comb begin
      state_in    = state_ff;
      page_in     = page_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      occ_in      = occ_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      hit_in      = hit_ff;
      evict_in    = evict_ff;
      removing_in = removing_ff;
      evpage_in   = evpage_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_evv_in   = rsp_evv_ff;
      rsp_evp_in   = rsp_evp_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_miss_in  = rsp_miss_ff;
      mem_we    = 1'b0;
      mem_wa    = '0;
      mem_wd    = page_ff;
      mem_re    = 1'b0;
      mem_ra    = '0;
      mod_start = 1'b0;
      lfsr_step = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               page_in  = req.page_number;
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of idx_ff-1 compared while idx_ff is fetched
            if (pend_ff && (mem_rd_ff == page_ff)) begin
               hit_in   = 1'b1;
               evict_in = 1'b0;
               pos_in   = AW'(idx_ff - OCC_W'(1));
               if (hit_cnt_ff != '1) begin
                  hit_cnt_in = hit_cnt_ff + COUNT_BITS'(1);
               end
               removing_in = pol_lru;
               state_in    = pol_lru ? ST_VREAD : ST_DONE;
            end else if (idx_ff < occ_ff) begin
               mem_re  = 1'b1;
               mem_ra  = idx_ff[AW-1:0];
               idx_in  = idx_ff + OCC_W'(1);
               pend_in = 1'b1;
            end else begin
               hit_in = 1'b0;
               if (miss_cnt_ff != '1) begin
                  miss_cnt_in = miss_cnt_ff + COUNT_BITS'(1);
               end
               evict_in    = table_full;
               removing_in = table_full;
               pos_in      = '0;
               if (!table_full) begin
                  state_in = ST_APPEND;
               end else if (pol_rand) begin
                  lfsr_step = 1'b1;
                  mod_start = 1'b1;
                  state_in  = ST_MODWAIT;
               end else begin
                  state_in = ST_VREAD;
               end
            end
         end
         ST_MODWAIT: begin
            if (mod_status.done) begin
               pos_in   = mod_rem[AW-1:0];
               state_in = ST_VREAD;
            end
         end
         ST_VREAD: begin
            mem_re   = 1'b1;
            mem_ra   = pos_ff;
            state_in = ST_VCAP;
         end
         ST_VCAP: begin
            evpage_in = mem_rd_ff;
            src_in    = OCC_W'(pos_ff) + OCC_W'(1);
            dst_in    = pos_ff;
            pend_in   = 1'b0;
            state_in  = ST_SHIFT;
         end
         ST_SHIFT: begin
            // close the gap: entry src moves down to dst
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = dst_ff;
               mem_wd = mem_rd_ff;
               dst_in = dst_ff + AW'(1);
            end
            if (src_ff < occ_ff) begin
               mem_re  = 1'b1;
               mem_ra  = src_ff[AW-1:0];
               src_in  = src_ff + OCC_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_APPEND;
               end
            end
         end
         ST_APPEND: begin
            mem_we = 1'b1;
            if (removing_ff) begin
               mem_wa = AW'(occ_ff - OCC_W'(1));
            end else begin
               mem_wa = occ_ff[AW-1:0];
               occ_in = occ_ff + OCC_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_evv_in   = evict_ff;
               rsp_evp_in   = evict_ff ? ev_wide[EVICT_BITS-1:0] : '0;
               rsp_hits_in  = hit_cnt_ff;
               rsp_miss_in  = miss_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         occ_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         occ_ff       <= occ_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff     <= page_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      hit_ff      <= hit_in;
      evict_ff    <= evict_in;
      removing_ff <= removing_in;
      evpage_ff   <= evpage_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_evv_ff  <= rsp_evv_in;
      rsp_evp_ff  <= rsp_evp_in;
      rsp_hits_ff <= rsp_hits_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign req.ready         = state_ff == ST_IDLE;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = rsp_hit_ff;
   assign rsp.evicted_valid = rsp_evv_ff;
   assign rsp.evicted_page  = rsp_evp_ff;
   assign rsp.hit_total     = rsp_hits_ff;
   assign rsp.miss_total    = rsp_miss_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(ENTRIES))
      else $error("occupancy above table depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND && !removing_ff) |=> occ_ff == $past(occ_ff) + OCC_W'(1))
      else $error("append without eviction did not grow the table");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> OCC_W'(dst_ff) < src_ff)
      else $error("compaction destination not below source");

   a_modwait_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODWAIT |-> (mod_status.busy || mod_status.done))
      else $error("waiting on an idle remainder unit");

   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hit_cnt_ff >= $past(hit_cnt_ff))
      else $error("hit count went down");

endmodule

`default_nettype wire

// ===== src/tlb_replacement_lookup.sv =====
// Request to response: the scan reads the table entry by entry and stops on a hit; a FIFO
// or random hit then responds, a miss with room appends and responds, and an eviction or
// LRU move reads the victim, compacts the table, appends and responds; a random victim
// first waits on the remainder unit. One request at a time is taken, and only while idle.
// Reset (synchronous): empties the table, clears counters, loads the seed into the LFSR.
// Holds the registers and victim LFSR; depends on tlbr_pkg, tlbr_if and tlbr_engine.
`default_nettype none

module tlb_replacement_lookup
   import tlbr_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   tlbr_req_if.sink                 req_ch,
   tlbr_rsp_if.source               rsp_ch,
   input  wire                      csr_write_enable,
   input  wire [CSR_INDEX_BITS-1:0] csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic [POLICY_BITS-1:0] policy_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic [LFSR_BITS-1:0]   lfsr_ff;
   logic [LFSR_BITS-1:0]   lfsr_adv;
   logic                   lfsr_step;
   tlbr_cfg_type           cfg;

   assign lfsr_adv   = tlbr_lfsr_next(lfsr_ff);
   assign cfg.policy = policy_ff;
   assign cfg.limit  = limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         limit_ff  <= LIMIT_RESET;
         lfsr_ff   <= tlbr_seed(SEED_RESET);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POLICY: policy_ff <= csr_write_data[POLICY_BITS-1:0];
            CSR_LIMIT:  limit_ff  <= csr_write_data[LIMIT_BITS-1:0];
            CSR_SEED:   lfsr_ff   <= tlbr_seed(csr_write_data[LFSR_BITS-1:0]);
            default:    ;
         endcase
      end else if (lfsr_step) begin
         lfsr_ff <= lfsr_adv;
      end
   end

   tlbr_engine #(
      .ENTRIES   (ENTRIES),
      .PAGE_BITS (PAGE_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .lfsr_adv  (lfsr_adv),
      .lfsr_step (lfsr_step),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire
